@@ src/dlps_pkg.sv @@
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared constants, codes, types and the slot address function of the
// lease pool server.
// ----------------------------------------------------------------------------
package dlps_pkg;

   localparam int POOL_SIZE  = 8;
   localparam int IDX_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CNT_W      = $clog2(POOL_SIZE + 1);
   localparam int SLOT_SHIFT = 24;

   localparam int ACTION_W = 3;
   localparam int MAC_W    = 48;
   localparam int IP_W     = 32;
   localparam int REPLY_W  = 2;
   localparam int OPT_W    = 5;

   localparam logic [ACTION_W-1:0] ACT_DISCOVER = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REQUEST  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INFORM   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DECLINE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RELEASE  = 3'd4;

   localparam logic [REPLY_W-1:0] REPLY_NONE  = 2'd0;
   localparam logic [REPLY_W-1:0] REPLY_OFFER = 2'd1;
   localparam logic [REPLY_W-1:0] REPLY_ACK   = 2'd2;
   localparam logic [REPLY_W-1:0] REPLY_NAK   = 2'd3;

   localparam logic [OPT_W-1:0] OPT_DNS      = 5'd1;
   localparam logic [OPT_W-1:0] OPT_SERVERID = 5'd2;
   localparam logic [OPT_W-1:0] OPT_ROUTER   = 5'd4;
   localparam logic [OPT_W-1:0] OPT_SUBNET   = 5'd8;
   localparam logic [OPT_W-1:0] OPT_LEASE    = 5'(1 << 4);
   localparam logic [OPT_W-1:0] OPTS_INFORM  = OPT_DNS | OPT_SERVERID | OPT_ROUTER | OPT_SUBNET;
   localparam logic [OPT_W-1:0] OPTS_FULL    = OPTS_INFORM | OPT_LEASE;

   typedef enum logic [2:0] {
      OP_DISCOVER,
      OP_REQUEST,
      OP_INFORM,
      OP_FREE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type           op;
      logic             mac_zero;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  req_ip;
      logic [IP_W-1:0]  client_ip;
   } cmd_type;

   typedef struct packed {
      logic [REPLY_W-1:0] reply;
      logic [IP_W-1:0]    your_ip;
      logic [IP_W-1:0]    client_ip_out;
      logic [OPT_W-1:0]   option_set;
   } rsp_type;

   // Entry k owns base + ((POOL_SIZE-1-k) << 24), wrapping at 32 bits.
   function automatic logic [IP_W-1:0] slot_addr(input logic [IP_W-1:0] base,
                                                  input logic [IDX_W-1:0] idx);
      logic [7:0] off;
      off = 8'(POOL_SIZE - 1) - 8'(idx);
      return base + (IP_W'(off) << SLOT_SHIFT);
   endfunction

endpackage

@@ src/dlps_ram.sv @@
// ----------------------------------------------------------------------------
// dlps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dlps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/dlps_front.sv @@
// ----------------------------------------------------------------------------
// dlps_front
// Accepts messages, classifies the action and holds them in a two-entry
// command queue for the lookup engine.
// ----------------------------------------------------------------------------
module dlps_front import dlps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [MAC_W-1:0]    req_client_mac,
   input  logic [IP_W-1:0]     req_requested_ip,
   input  logic [IP_W-1:0]     req_client_ip,
   output logic                cmd_valid,
   output cmd_type             cmd_data,
   input  logic                cmd_take
);

   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, take_ok;

   always_comb begin
      cmd_in.mac       = req_client_mac;
      cmd_in.mac_zero  = (req_client_mac == '0);
      cmd_in.req_ip    = req_requested_ip;
      cmd_in.client_ip = req_client_ip;
      case (req_action)
         ACT_DISCOVER:             cmd_in.op = OP_DISCOVER;
         ACT_REQUEST:              cmd_in.op = OP_REQUEST;
         ACT_INFORM:               cmd_in.op = OP_INFORM;
         ACT_DECLINE, ACT_RELEASE: cmd_in.op = OP_FREE;
         default:                  cmd_in.op = OP_NONE;
      endcase
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];
   assign push_ok   = push && !full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = push_ok ? !wr_ff : wr_ff;
      rd_in  = take_ok ? !rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push_ok && !take_ok) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push_ok && take_ok) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ src/dlps_back.sv @@
// ----------------------------------------------------------------------------
// dlps_back
// Lookup engine: holds the binding table and base address, scans the table
// one entry a cycle for each command, decides the reply, binds or frees
// entries and queues the result in a two-entry output queue.
// ----------------------------------------------------------------------------
module dlps_back import dlps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [IP_W-1:0] csr_wr_data,
   input  logic            cmd_valid,
   input  cmd_type         cmd_data,
   output logic            cmd_take,
   output logic            empty,
   input  logic            pop,
   output rsp_type         rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOOKUP,
      ST_REPLY
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [IP_W-1:0]      base_ff, base_in;
   logic [POOL_SIZE-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     fidx_ff, fidx_in;
   logic                 cand_ff, cand_in;
   logic [IDX_W-1:0]     cidx_ff, cidx_in;
   logic [IP_W-1:0]      lookup_ff, lookup_in;

   rsp_type              rq_ff [2];
   rsp_type              rsp_in;
   logic                 rq_wr_ff, rq_wr_in;
   logic                 rq_rd_ff, rq_rd_in;
   logic [1:0]           rq_cnt_ff, rq_cnt_in;
   logic                 rq_push, rq_pop;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [MAC_W-1:0]     ram_rd_data;
   logic [MAC_W-1:0]     entry;

   dlps_ram #(
      .WIDTH (MAC_W),
      .DEPTH (POOL_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cidx_ff),
      .wr_data (cmd_ff.mac),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // An entry without its valid bit is free and reads as zero.
   assign entry       = valid_ff[pidx_ff] ? ram_rd_data : '0;
   assign ram_rd_addr = issue_ff[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      base_in   = base_ff;
      valid_in  = valid_ff;
      issue_in  = issue_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      fidx_in   = fidx_ff;
      cand_in   = cand_ff;
      cidx_in   = cidx_ff;
      lookup_in = lookup_ff;
      cmd_take  = 1'b0;
      ram_wr_en = 1'b0;
      rq_push   = 1'b0;
      rsp_in    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               issue_in = '0;
               found_in = 1'b0;
               cand_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Reads are issued one a cycle; the RAM registers the data of each.
            if (issue_ff < CNT_W'(POOL_SIZE)) begin
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
               pidx_in  = issue_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (!cmd_ff.mac_zero && entry == cmd_ff.mac) begin
                  if (!found_ff) begin
                     found_in = 1'b1;
                     fidx_in  = pidx_ff;
                  end
                  if (cmd_ff.op == OP_FREE) begin
                     valid_in[pidx_ff] = 1'b0;
                  end
               end
               if (entry == '0) begin
                  cand_in = 1'b1;
                  cidx_in = pidx_ff;
               end
               if (pidx_ff == IDX_W'(POOL_SIZE - 1)) begin
                  state_in = ST_LOOKUP;
               end
            end
         end

         ST_LOOKUP: begin
            if (cmd_ff.mac_zero) begin
               lookup_in = '0;
            end else if (found_ff) begin
               lookup_in = slot_addr(base_ff, fidx_ff);
            end else if (cand_ff) begin
               lookup_in = slot_addr(base_ff, cidx_ff);
            end else begin
               lookup_in = '0;
            end
            state_in = ST_REPLY;
         end

         ST_REPLY: begin
            case (cmd_ff.op)
               OP_DISCOVER: begin
                  if (lookup_ff != '0) begin
                     rsp_in.reply         = REPLY_OFFER;
                     rsp_in.your_ip       = lookup_ff;
                     rsp_in.client_ip_out = cmd_ff.client_ip;
                     rsp_in.option_set    = OPTS_FULL;
                  end
               end
               OP_REQUEST: begin
                  if (cmd_ff.req_ip != '0 && cmd_ff.req_ip == lookup_ff) begin
                     rsp_in.reply         = REPLY_ACK;
                     rsp_in.your_ip       = cmd_ff.req_ip;
                     rsp_in.client_ip_out = cmd_ff.client_ip;
                     rsp_in.option_set    = OPTS_FULL;
                  end else begin
                     rsp_in.reply = REPLY_NAK;
                  end
               end
               OP_INFORM: begin
                  if (cmd_ff.client_ip != '0 && cmd_ff.client_ip == lookup_ff) begin
                     rsp_in.reply         = REPLY_ACK;
                     rsp_in.client_ip_out = cmd_ff.client_ip;
                     rsp_in.option_set    = OPTS_INFORM;
                  end
               end
               default: begin
                  rsp_in.reply = REPLY_NONE;
               end
            endcase
            if (rq_cnt_ff != 2'd2) begin
               rq_push = 1'b1;
               // A nonzero address without a match means the last free entry
               // was chosen, so the client is bound to it.
               if (cmd_ff.op == OP_DISCOVER && !found_ff && lookup_ff != '0) begin
                  ram_wr_en         = 1'b1;
                  valid_in[cidx_ff] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         base_in  = csr_wr_data;
         valid_in = '0;
      end
   end

   assign empty    = (rq_cnt_ff == 2'd0);
   assign rsp_data = rq_ff[rq_rd_ff];
   assign rq_pop   = pop && !empty;

   always_comb begin
      rq_wr_in  = rq_push ? !rq_wr_ff : rq_wr_ff;
      rq_rd_in  = rq_pop ? !rq_rd_ff : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rq_push && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 2'd1;
      end else if (!rq_push && rq_pop) begin
         rq_cnt_in = rq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      issue_ff  <= issue_in;
      pidx_ff   <= pidx_in;
      fidx_ff   <= fidx_in;
      cidx_ff   <= cidx_in;
      lookup_ff <= lookup_in;
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= rsp_in;
      end
      if (reset) begin
         state_ff  <= ST_IDLE;
         base_ff   <= '0;
         valid_ff  <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         cand_ff   <= 1'b0;
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         valid_ff  <= valid_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         cand_ff   <= cand_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

endmodule

@@ src/dhcp_lease_pool_server.sv @@
// ----------------------------------------------------------------------------
// dhcp_lease_pool_server
// Address pool of a DHCP server: binds client hardware addresses to pool
// entries and decides the reply to each message.
// ----------------------------------------------------------------------------
// Usage:
// Messages enter through a queue-style port: a transfer happens at a clock
// edge with push high and full low. Results leave the same way: the oldest
// result is on the rsp_ ports while empty is low and is taken by pop.
// Every message gives exactly one result, with reply code zero when there
// is nothing to send. The base register is written through csr_wr_en and
// csr_wr_data; a write also frees every binding.
// Each message scans the table one entry a cycle through the table RAM's
// read port, then passes through the lookup and reply states; the engine
// takes the next message only once its result is queued. Two messages
// may wait in the command queue meanwhile. Reset clears every binding
// and the base address at once. When the receiver stalls, up to two
// results wait in the output queue; after that the engine holds its
// result and the command queue fills, raising full.
// ----------------------------------------------------------------------------
module dhcp_lease_pool_server import dlps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [MAC_W-1:0]    req_client_mac,
   input  logic [IP_W-1:0]     req_requested_ip,
   input  logic [IP_W-1:0]     req_client_ip,
   output logic                empty,
   input  logic                pop,
   output logic [REPLY_W-1:0]  rsp_reply,
   output logic [IP_W-1:0]     rsp_your_ip,
   output logic [IP_W-1:0]     rsp_client_ip_out,
   output logic [OPT_W-1:0]    rsp_option_set,
   input  logic                csr_wr_en,
   input  logic [IP_W-1:0]     csr_wr_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;
   rsp_type rsp_data;

   dlps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_client_mac   (req_client_mac),
      .req_requested_ip (req_requested_ip),
      .req_client_ip    (req_client_ip),
      .cmd_valid        (cmd_valid),
      .cmd_data         (cmd_data),
      .cmd_take         (cmd_take)
   );

   dlps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_take    (cmd_take),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

   assign rsp_reply         = rsp_data.reply;
   assign rsp_your_ip       = rsp_data.your_ip;
   assign rsp_client_ip_out = rsp_data.client_ip_out;
   assign rsp_option_set    = rsp_data.option_set;

endmodule

@@ tb/tb_dhcp_lease_pool_server.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dhcp_lease_pool_server
// Self-checking bench for the DHCP lease pool. Messages go in through the
// push/full port and replies come out through empty/pop. A model of the
// binding table in the bench predicts every reply, and each popped reply is
// compared field by field with the oldest expected reply. A short directed plan
// is followed by random client conversations under several base addresses
// and idle patterns. One stretch of receiver back-pressure fills the block.
// ----------------------------------------------------------------------------
module tb_dhcp_lease_pool_server import dlps_pkg::*; ();

   localparam logic [ACTION_W-1:0] ACT_OTHER   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam int NUM_CLIENTS = 12;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 190;
   localparam int SETTLE      = POOL_SIZE + 8;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   localparam rsp_type SILENT  = '{REPLY_NONE, 32'h0, 32'h0, 5'h0};
   localparam rsp_type NAK_RSP = '{REPLY_NAK, 32'h0, 32'h0, 5'h0};

   localparam logic [MAC_W-1:0] MAC_A   = 48'h0200_0000_00A1;
   localparam logic [MAC_W-1:0] MAC_B   = 48'h0200_0000_00B2;
   localparam logic [MAC_W-1:0] MAC_C   = 48'h0200_0000_00C3;
   localparam logic [MAC_W-1:0] MAC_D   = 48'h0200_0000_00D4;
   localparam logic [MAC_W-1:0] MAC_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [MAC_W-1:0]    mac;
      logic [IP_W-1:0]     req_ip;
      logic [IP_W-1:0]     ci;
   } dhcp_msg_type;

   typedef struct {
      bit              is_cfg;
      logic [IP_W-1:0] cfg_val;
      dhcp_msg_type    msg;
      bit              typed;
      rsp_type         want;
   } plan_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [ACTION_W-1:0] req_action = '0;
   logic [MAC_W-1:0]    req_client_mac = '0;
   logic [IP_W-1:0]     req_requested_ip = '0;
   logic [IP_W-1:0]     req_client_ip = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [REPLY_W-1:0]  rsp_reply;
   logic [IP_W-1:0]     rsp_your_ip;
   logic [IP_W-1:0]     rsp_client_ip_out;
   logic [OPT_W-1:0]    rsp_option_set;
   logic                csr_wr_en = 1'b0;
   logic [IP_W-1:0]     csr_wr_data = '0;

   // Bench copy of the binding table and base register.
   logic [MAC_W-1:0] lease_mac [POOL_SIZE];
   logic [IP_W-1:0]  pool_base;

   rsp_type          owed_replies [$];
   plan_row_type     plan [$];
   logic [MAC_W-1:0] clients [NUM_CLIENTS];

   int send_idle_pct = 27;
   int recv_idle_pct = 50;
   int stall_seq = 0;
   int stall_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int full_stalls = 0;
   int msgs_sent = 0;
   int base_writes = 0;
   int cycle_count = 0;
   int reply_tally [4] = '{0, 0, 0, 0};

   dhcp_lease_pool_server uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_client_mac   (req_client_mac),
      .req_requested_ip (req_requested_ip),
      .req_client_ip    (req_client_ip),
      .empty            (empty),
      .pop              (pop),
      .rsp_reply        (rsp_reply),
      .rsp_your_ip      (rsp_your_ip),
      .rsp_client_ip_out(rsp_client_ip_out),
      .rsp_option_set   (rsp_option_set),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [IP_W-1:0] entry_ip(int k);
      return pool_base + (IP_W'((POOL_SIZE - 1 - k) & 8'hFF) << SLOT_SHIFT);
   endfunction

   // Address for a client: its own entry if bound, otherwise the last free
   // entry of the scan. The free entry is claimed only when its address is
   // nonzero.
   function automatic logic [IP_W-1:0] lease_lookup(logic [MAC_W-1:0] mac, bit claim);
      int k;
      int spare;
      logic [IP_W-1:0] found;
      if (mac == '0)
         return '0;
      spare = -1;
      for (k = 0; k < POOL_SIZE; k++) begin
         if (lease_mac[k] == mac)
            return entry_ip(k);
         if (lease_mac[k] == '0)
            spare = k;
      end
      if (spare < 0)
         return '0;
      found = entry_ip(spare);
      if (claim && found != '0)
         lease_mac[spare] = mac;
      return found;
   endfunction

   function automatic rsp_type predict_reply(dhcp_msg_type m);
      rsp_type r;
      logic [IP_W-1:0] ip;
      int k;
      r = SILENT;
      case (m.action)
         ACT_DISCOVER: begin
            ip = lease_lookup(m.mac, 1'b1);
            if (ip != '0)
               r = '{REPLY_OFFER, ip, m.ci, OPTS_FULL};
         end
         ACT_REQUEST: begin
            if (m.req_ip != '0 && m.req_ip == lease_lookup(m.mac, 1'b0))
               r = '{REPLY_ACK, m.req_ip, m.ci, OPTS_FULL};
            else
               r = NAK_RSP;
         end
         ACT_INFORM: begin
            if (m.ci != '0 && m.ci == lease_lookup(m.mac, 1'b0))
               r = '{REPLY_ACK, 32'h0, m.ci, OPTS_INFORM};
         end
         ACT_DECLINE, ACT_RELEASE: begin
            for (k = 0; k < POOL_SIZE; k++)
               if (lease_mac[k] == m.mac)
                  lease_mac[k] = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic plan_row_type msg_row(logic [ACTION_W-1:0] act, logic [MAC_W-1:0] mac,
                                            logic [IP_W-1:0] req, logic [IP_W-1:0] ci,
                                            bit typed = 1'b0, rsp_type want = SILENT);
      plan_row_type row;
      row.is_cfg  = 1'b0;
      row.cfg_val = '0;
      row.msg     = '{act, mac, req, ci};
      row.typed   = typed;
      row.want    = want;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(logic [IP_W-1:0] value);
      plan_row_type row;
      row = msg_row(ACT_OTHER, '0, '0, '0);
      row.is_cfg  = 1'b1;
      row.cfg_val = value;
      return row;
   endfunction

   // Mostly well-formed client conversations that follow the table, with a
   // share of stray addresses and fully random messages mixed in.
   function automatic dhcp_msg_type random_msg();
      dhcp_msg_type m;
      logic [IP_W-1:0] held;
      int roll;
      if ($urandom_range(99) < 10) begin
         m.action = ACTION_W'($urandom_range(ACT_SPARE_7));
         m.mac    = MAC_W'({$urandom(), $urandom()});
         m.req_ip = $urandom();
         m.ci     = $urandom();
         return m;
      end
      roll = $urandom_range(99);
      if (roll < 5)
         m.mac = '0;
      else if (roll < 10)
         m.mac = MAC_W'({$urandom(), $urandom()});
      else
         m.mac = clients[$urandom_range(NUM_CLIENTS - 1)];
      roll = $urandom_range(99);
      if (roll < 34)
         m.action = ACT_DISCOVER;
      else if (roll < 60)
         m.action = ACT_REQUEST;
      else if (roll < 73)
         m.action = ACT_INFORM;
      else if (roll < 87)
         m.action = ACT_RELEASE;
      else if (roll < 94)
         m.action = ACT_DECLINE;
      else
         m.action = ACTION_W'($urandom_range(ACT_SPARE_7, ACT_OTHER));
      held = lease_lookup(m.mac, 1'b0);
      roll = $urandom_range(99);
      if (roll < 65)
         m.req_ip = held;
      else if (roll < 75)
         m.req_ip = '0;
      else if (roll < 88)
         m.req_ip = held + (IP_W'($urandom_range(1, POOL_SIZE - 1)) << SLOT_SHIFT);
      else
         m.req_ip = $urandom();
      roll = $urandom_range(99);
      if (m.action == ACT_INFORM && roll < 60)
         m.ci = held;
      else if (roll < 80)
         m.ci = '0;
      else
         m.ci = $urandom();
      return m;
   endfunction

   task automatic send(input dhcp_msg_type m, input bit typed, input rsp_type want);
      int gap;
      rsp_type predicted;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push             <= 1'b1;
      req_action       <= m.action;
      req_client_mac   <= m.mac;
      req_requested_ip <= m.req_ip;
      req_client_ip    <= m.ci;
      do @(posedge clock); while (full);
      predicted = predict_reply(m);
      owed_replies.push_back(typed ? want : predicted);
      msgs_sent++;
   endtask

   // Stop offering messages and wait until every reply has been popped and
   // the engine has had time to settle.
   task automatic drain_all();
      push <= 1'b0;
      while (owed_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_base(input logic [IP_W-1:0] value);
      int k;
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pool_base = value;
      for (k = 0; k < POOL_SIZE; k++)
         lease_mac[k] = '0;
      base_writes++;
   endtask

   // Receiver: random pops, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         pop        <= 1'b0;
         hold_left  <= 0;
         stall_seen <= stall_seq;
      end else if (stall_seen != stall_seq) begin
         stall_seen <= stall_seq;
         hold_left  <= HOLD_CYCLES;
         pop        <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Reply checker: every transfer out is matched against the oldest
   // expected reply.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && push && full)
         full_stalls++;
      if (!reset && pop && !empty) begin
         if (owed_replies.size() == 0) begin
            $error("reply %0d arrived with no message outstanding", rsp_reply);
            errors++;
         end else begin
            want = owed_replies.pop_front();
            reply_tally[want.reply]++;
            if (rsp_reply !== want.reply) begin
               $error("reply: expected %0d, got %0d", want.reply, rsp_reply);
               errors++;
            end
            if (rsp_your_ip !== want.your_ip) begin
               $error("your_ip: expected %h, got %h", want.your_ip, rsp_your_ip);
               errors++;
            end
            if (rsp_client_ip_out !== want.client_ip_out) begin
               $error("client_ip_out: expected %h, got %h", want.client_ip_out,
                      rsp_client_ip_out);
               errors++;
            end
            if (rsp_option_set !== want.option_set) begin
               $error("option_set: expected %h, got %h", want.option_set, rsp_option_set);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [IP_W-1:0] seg_base [SEGMENTS];
      int k;
      int seg;
      int i;

      for (k = 0; k < POOL_SIZE; k++)
         lease_mac[k] = '0;
      pool_base = '0;
      for (k = 0; k < NUM_CLIENTS; k++)
         clients[k] = MAC_W'({$urandom(), $urandom()}) | MAC_W'(1);

      // With a zero base the last entry owns address zero, so nothing binds.
      plan.push_back(msg_row(ACT_DISCOVER, MAC_A, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_REQUEST, MAC_A, 32'h0, 32'h0, 1'b1, NAK_RSP));
      plan.push_back(msg_row(ACT_INFORM, MAC_A, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_OTHER, MAC_A, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(cfg_row(32'h0A00_0001));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_A, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_B, 32'h0, 32'h1234_5678));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_A, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_REQUEST, MAC_A, 32'h0A00_0001, 32'h0));
      plan.push_back(msg_row(ACT_REQUEST, MAC_B, 32'h0A00_0001, 32'h0, 1'b1, NAK_RSP));
      plan.push_back(msg_row(ACT_INFORM, MAC_B, 32'h0, 32'h0B00_0001));
      // A zero hardware address matches nothing.
      plan.push_back(msg_row(ACT_INFORM, 48'h0, 32'h0, 32'h0A00_0001, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_DISCOVER, 48'h0, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_REQUEST, 48'h0, 32'h0A00_0001, 32'h0, 1'b1, NAK_RSP));
      plan.push_back(msg_row(ACT_RELEASE, MAC_A, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_DECLINE, MAC_B, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(msg_row(ACT_SPARE_7, MAC_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                             SILENT));
      plan.push_back(msg_row(ACT_SPARE_6, MAC_C, 32'h0, 32'h0, 1'b1, SILENT));
      plan.push_back(cfg_row(32'hFFFF_FFFF));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_MAX, 32'h0, 32'hFFFF_FFFF));
      plan.push_back(msg_row(ACT_REQUEST, MAC_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // Here the fifth entry wraps to address zero, so a fourth client is
      // left without an offer although entries are free.
      plan.push_back(cfg_row(32'hFD00_0000));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_A, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_B, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_C, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_DISCOVER, MAC_D, 32'h0, 32'h0));
      plan.push_back(msg_row(ACT_REQUEST, MAC_C, 32'hFF00_0000, 32'h0A0B_0C0D));

      seg_base[0] = 32'hFFFF_FFFF;
      seg_base[1] = 32'hFD00_0000;
      seg_base[2] = $urandom();
      seg_base[3] = 32'h0000_0000;
      seg_base[4] = $urandom();
      seg_base[5] = 32'h0100_0000;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_cfg)
            write_base(plan[k].cfg_val);
         else
            send(plan[k].msg, plan[k].typed, plan[k].want);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         write_base(seg_base[seg]);
         send_idle_pct  = (seg < 2) ? 27 : (seg < 4) ? 50 : 0;
         recv_idle_pct <= (seg < 2) ? 50 : (seg < 4) ? 27 : 0;
         // Long receiver hold-off while messages keep coming, so the block
         // fills up and pushes back on its input.
         if (seg == 4)
            stall_seq <= stall_seq + 1;
         for (i = 0; i < SEG_ITEMS; i++) begin
            if (seg == 2 && i == SEG_ITEMS / 2)
               drain_all();
            send(random_msg(), 1'b0, SILENT);
         end
      end

      drain_all();
      $display("Checked %0d messages over %0d base settings: %0d offers, %0d acks, %0d naks,",
               msgs_sent, base_writes, reply_tally[REPLY_OFFER], reply_tally[REPLY_ACK],
               reply_tally[REPLY_NAK]);
      $display("%0d silent replies; input held off by a full block for %0d cycles.",
               reply_tally[REPLY_NONE], full_stalls);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
src/dlps_pkg.sv
src/dlps_ram.sv
src/dlps_front.sv
src/dlps_back.sv
src/dhcp_lease_pool_server.sv
tb/tb_dhcp_lease_pool_server.sv
